FILE: rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, codes, stage records and helpers of the collision pair test.
// ----------------------------------------------------------------------------
package cpt_pkg;

	// Coordinate component width (signed fixed point); fields pack three of them.
	localparam int COORD_BITS = 16;
	localparam int NCOMP      = 3;
	localparam int POS_W      = 48;
	localparam int MASK_W     = 32;

	// Derived arithmetic widths
	localparam int DW   = COORD_BITS + 2;   // relative motion component
	localparam int SW   = COORD_BITS + 1;   // start difference component
	localparam int RW   = COORD_BITS + 1;   // summed radius
	localparam int PW   = 2 * DW;           // one component product
	localparam int WW   = 2 * DW + 2;       // quadratic coefficients
	localparam int EW   = WW + 2;           // a + 2*bh + c
	localparam int MW   = WW - 1;           // nonnegative coefficient magnitude
	localparam int HW   = (MW + 1) / 2;     // low half of a split operand
	localparam int UW   = MW - HW;          // high half of a split operand
	localparam int PPW  = 2 * HW;           // partial product
	localparam int FW   = 2 * MW;           // full square / product
	localparam int BDW  = COORD_BITS + 3;   // box clamp distance component
	localparam int BSQ  = 2 * BDW;
	localparam int BSUM = BSQ + 2;
	localparam int BRR  = 2 * COORD_BITS;

	typedef enum logic [1:0] {
		KIND_SPH_SPH = 2'd0,
		KIND_BOX_SPH = 2'd1,
		KIND_SPH_BOX = 2'd2,
		KIND_BOX_BOX = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [MASK_W-1:0] a_attribute;
		logic [MASK_W-1:0] a_mask;
		logic [MASK_W-1:0] b_attribute;
		logic [MASK_W-1:0] b_mask;
		logic [POS_W-1:0]  a_prev_pos;
		logic [POS_W-1:0]  a_curr_pos;
		logic [POS_W-1:0]  b_prev_pos;
		logic [POS_W-1:0]  b_curr_pos;
		logic [POS_W-1:0]  a_extent;
		logic [POS_W-1:0]  b_extent;
	} req_t;

	typedef struct packed {
		logic                            pass;
		kind_t                           kind;
		logic [NCOMP-1:0][DW-1:0]        d;
		logic [NCOMP-1:0][SW-1:0]        st;
		logic [RW-1:0]                   rsum;
		logic [NCOMP-1:0][BDW-1:0]       bd;
		logic [COORD_BITS-1:0]           br;
	} s1_t;

	typedef struct packed {
		logic                            pass;
		kind_t                           kind;
		logic [NCOMP-1:0][PW-1:0]        dd;
		logic [NCOMP-1:0][PW-1:0]        sd;
		logic [NCOMP-1:0][PW-1:0]        ss;
		logic [2*RW-1:0]                 rr;
		logic [NCOMP-1:0][BSQ-1:0]       bsq;
		logic [BRR-1:0]                  brr;
	} s2_t;

	typedef struct packed {
		logic                            pass;
		kind_t                           kind;
		logic                            bhit;
		logic signed [WW-1:0]            a;
		logic signed [WW-1:0]            bh;
		logic signed [WW-1:0]            c;
	} s3_t;

	typedef struct packed {
		logic                            pass;
		kind_t                           kind;
		logic                            bhit;
		logic                            decided;
		logic                            dhit;
		logic [PPW-1:0]                  p_hh;
		logic [PPW-1:0]                  p_hl;
		logic [PPW-1:0]                  p_ll;
		logic [PPW-1:0]                  q_hh;
		logic [PPW-1:0]                  q_hl;
		logic [PPW-1:0]                  q_lh;
		logic [PPW-1:0]                  q_ll;
	} s4_t;

	typedef struct packed {
		logic                            pass;
		kind_t                           kind;
		logic                            bhit;
		logic                            decided;
		logic                            dhit;
		logic [FW-1:0]                   lhs;
		logic [FW-1:0]                   rhs;
	} s5_t;

	function automatic logic signed [COORD_BITS-1:0] comp_s(input logic [POS_W-1:0] v,
			input int i);
		return $signed(v[i*COORD_BITS +: COORD_BITS]);
	endfunction

	function automatic logic [COORD_BITS-1:0] comp_u(input logic [POS_W-1:0] v, input int i);
		return v[i*COORD_BITS +: COORD_BITS];
	endfunction

endpackage

FILE: rtl/cpt_if.sv
// ----------------------------------------------------------------------------
// cpt_req_if / cpt_rsp_if
// Valid/ready channels carrying one pair test and its result.
// ----------------------------------------------------------------------------
interface cpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] a_attribute;
	logic [31:0] a_mask;
	logic [31:0] b_attribute;
	logic [31:0] b_mask;
	logic [47:0] a_prev_pos;
	logic [47:0] a_curr_pos;
	logic [47:0] b_prev_pos;
	logic [47:0] b_curr_pos;
	logic [47:0] a_extent;
	logic [47:0] b_extent;

	modport source (output valid, kind, a_attribute, a_mask, b_attribute, b_mask,
		a_prev_pos, a_curr_pos, b_prev_pos, b_curr_pos, a_extent, b_extent,
		input ready);
	modport sink (input valid, kind, a_attribute, a_mask, b_attribute, b_mask,
		a_prev_pos, a_curr_pos, b_prev_pos, b_curr_pos, a_extent, b_extent,
		output ready);
endinterface

interface cpt_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic filter_pass;

	modport source (output valid, hit, filter_pass, input ready);
	modport sink (input valid, hit, filter_pass, output ready);
endinterface

FILE: rtl/collision_pair_test.sv
// ----------------------------------------------------------------------------
// collision_pair_test
// Narrow-phase test of one pair of collision shapes, fully pipelined.
// ----------------------------------------------------------------------------
// One pair test enters per cycle unless the result side stalls, and its
// result beat leaves after five compute stages and the output register, at
// one beat per cycle while unstalled. Stages: the input filter and component
// differences, the component products, the coefficient sums, the early root
// decisions with split partial products, and the recombination of those
// products; the final compare lands in the output register. Each stage
// advances whenever the stage after it is empty or advancing, so a stall on
// the result side backs up without losing or repeating a beat, and bubbles
// are squeezed out. There is no state between pairs and no configuration.
// A sphere pair is a swept test over the frame, a box/sphere pair is tested
// at the current positions, and a box pair never hits. A pair whose filter
// fails reports neither hit nor filter pass.
// ----------------------------------------------------------------------------
module collision_pair_test
	import cpt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	cpt_req_if.sink       req,
	cpt_rsp_if.source     rsp
);
	req_t req_d;
	s1_t  s1_d, p_s1;
	s2_t  s2_d, p_s2;
	s3_t  s3_d, p_s3;
	s4_t  s4_d, p_s4;
	s5_t  s5_d, p_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;
	logic hit_s6, pass_s6;
	logic hit_d;

	// pack the request beat
	always_comb begin
		req_d.kind        = req.kind;
		req_d.a_attribute = req.a_attribute;
		req_d.a_mask      = req.a_mask;
		req_d.b_attribute = req.b_attribute;
		req_d.b_mask      = req.b_mask;
		req_d.a_prev_pos  = req.a_prev_pos;
		req_d.a_curr_pos  = req.a_curr_pos;
		req_d.b_prev_pos  = req.b_prev_pos;
		req_d.b_curr_pos  = req.b_curr_pos;
		req_d.a_extent    = req.a_extent;
		req_d.b_extent    = req.b_extent;
	end

	cpt_prep  u_prep  (.req_d(req_d), .s1_d(s1_d));
	cpt_mult  u_mult  (.s1_q(p_s1),  .s2_d(s2_d));
	cpt_accum u_accum (.s2_q(p_s2),  .s3_d(s3_d));
	cpt_split u_split (.s3_q(p_s3),  .s4_d(s4_d));
	cpt_merge u_merge (.s4_q(p_s4),  .s5_d(s5_d));

	// a stage loads when it is empty or its contents move on
	assign adv6 = !v_s6 || rsp.ready;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign req.ready = adv1;

	// final selection: swept sphere result, box/sphere result, or none
	always_comb begin
		logic sph;
		sph = p_s5.decided ? p_s5.dhit : (p_s5.lhs >= p_s5.rhs);
		unique case (p_s5.kind)
			KIND_SPH_SPH: hit_d = p_s5.pass && sph;
			KIND_BOX_SPH,
			KIND_SPH_BOX: hit_d = p_s5.pass && p_s5.bhit;
			KIND_BOX_BOX: hit_d = 1'b0;
			default:      hit_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// payload: hold while stalled, advance with the valid bits
	always_ff @(posedge clk) begin
		if (adv1) p_s1 <= s1_d;
		if (adv2) p_s2 <= s2_d;
		if (adv3) p_s3 <= s3_d;
		if (adv4) p_s4 <= s4_d;
		if (adv5) p_s5 <= s5_d;
		if (adv6) begin
			hit_s6  <= hit_d;
			pass_s6 <= p_s5.pass;
		end
	end

	assign rsp.valid       = v_s6;
	assign rsp.hit         = hit_s6;
	assign rsp.filter_pass = pass_s6;

`ifndef SYNTHESIS
	a_hit_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> rsp.filter_pass)
		else $error("hit reported without filter pass");

	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s6 |-> req.ready)
		else $error("input stalled with empty output stage");

	a_early_miss: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && adv6 && p_s5.kind == KIND_SPH_SPH && p_s5.decided && !p_s5.dhit
		|=> !hit_s6)
		else $error("early sphere miss turned into a hit");
`endif
endmodule

FILE: rtl/cpt_prep.sv
// ----------------------------------------------------------------------------
// cpt_prep
// First stage: filter, unpack components, form differences and box clamp.
// ----------------------------------------------------------------------------
module cpt_prep
	import cpt_pkg::*;
(
	input  req_t req_d,
	output s1_t  s1_d
);
	logic [POS_W-1:0] box_pos, box_ext, sph_pos, sph_ext;

	always_comb begin
		if (req_d.kind == KIND_SPH_BOX) begin
			box_pos = req_d.b_curr_pos;
			box_ext = req_d.b_extent;
			sph_pos = req_d.a_curr_pos;
			sph_ext = req_d.a_extent;
		end else begin
			box_pos = req_d.a_curr_pos;
			box_ext = req_d.a_extent;
			sph_pos = req_d.b_curr_pos;
			sph_ext = req_d.b_extent;
		end
	end

	always_comb begin
		logic signed [DW-1:0]  pa, ca, pb, cb;
		logic signed [BDW-1:0] p, e, lo, hi, cc;
		s1_d.pass = ((req_d.a_attribute & req_d.b_mask) != '0) &&
			((req_d.a_mask & req_d.b_attribute) != '0);
		s1_d.kind = kind_t'(req_d.kind);
		for (int i = 0; i < NCOMP; i++) begin
			pa = DW'(comp_s(req_d.a_prev_pos, i));
			ca = DW'(comp_s(req_d.a_curr_pos, i));
			pb = DW'(comp_s(req_d.b_prev_pos, i));
			cb = DW'(comp_s(req_d.b_curr_pos, i));
			s1_d.d[i]  = (ca - pa) - (cb - pb);
			s1_d.st[i] = SW'(pa - pb);
			// clamp sphere center onto the box, keep the offset
			p  = BDW'(comp_s(box_pos, i));
			e  = BDW'($signed({1'b0, comp_u(box_ext, i)}));
			cc = BDW'(comp_s(sph_pos, i));
			lo = p - e;
			hi = p + e;
			if (cc < lo)
				s1_d.bd[i] = lo - cc;
			else if (cc > hi)
				s1_d.bd[i] = hi - cc;
			else
				s1_d.bd[i] = '0;
		end
		s1_d.rsum = RW'(comp_u(req_d.a_extent, 0)) + RW'(comp_u(req_d.b_extent, 0));
		s1_d.br   = comp_u(sph_ext, 0);
	end
endmodule

FILE: rtl/cpt_mult.sv
// ----------------------------------------------------------------------------
// cpt_mult
// Second stage: component products and squared radii.
// ----------------------------------------------------------------------------
module cpt_mult
	import cpt_pkg::*;
(
	input  s1_t s1_q,
	output s2_t s2_d
);
	always_comb begin
		logic signed [PW-1:0]  dx, sx;
		logic signed [BSQ-1:0] bx;
		s2_d.pass = s1_q.pass;
		s2_d.kind = s1_q.kind;
		for (int i = 0; i < NCOMP; i++) begin
			dx = PW'($signed(s1_q.d[i]));
			sx = PW'($signed(s1_q.st[i]));
			s2_d.dd[i] = dx * dx;
			s2_d.sd[i] = sx * dx;
			s2_d.ss[i] = sx * sx;
			bx = BSQ'($signed(s1_q.bd[i]));
			s2_d.bsq[i] = bx * bx;
		end
		s2_d.rr  = (2*RW)'(s1_q.rsum) * (2*RW)'(s1_q.rsum);
		s2_d.brr = BRR'(s1_q.br) * BRR'(s1_q.br);
	end
endmodule

FILE: rtl/cpt_accum.sv
// ----------------------------------------------------------------------------
// cpt_accum
// Third stage: sum components into quadratic coefficients; finish box test.
// ----------------------------------------------------------------------------
module cpt_accum
	import cpt_pkg::*;
(
	input  s2_t s2_q,
	output s3_t s3_d
);
	always_comb begin
		logic signed [WW-1:0]   s;
		logic signed [BSUM-1:0] bsum;
		s3_d.pass = s2_q.pass;
		s3_d.kind = s2_q.kind;
		s3_d.a    = '0;
		s3_d.bh   = '0;
		s        = '0;
		bsum     = '0;
		for (int i = 0; i < NCOMP; i++) begin
			s3_d.a  = s3_d.a  + WW'($signed(s2_q.dd[i]));
			s3_d.bh = s3_d.bh + WW'($signed(s2_q.sd[i]));
			s       = s       + WW'($signed(s2_q.ss[i]));
			bsum    = bsum    + BSUM'($signed(s2_q.bsq[i]));
		end
		s3_d.c    = s - WW'($signed({1'b0, s2_q.rr}));
		s3_d.bhit = bsum <= BSUM'($signed({1'b0, s2_q.brr}));
	end
endmodule

FILE: rtl/cpt_split.sv
// ----------------------------------------------------------------------------
// cpt_split
// Fourth stage: early root decisions and split partial products.
// ----------------------------------------------------------------------------
module cpt_split
	import cpt_pkg::*;
(
	input  s3_t s3_q,
	output s4_t s4_d
);
	always_comb begin
		logic signed [WW-1:0]  nbh;
		logic signed [EW-1:0]  e1;
		logic signed [WW:0]    e2;
		logic                  zero_a, fail, le0, neg;
		logic [MW-1:0]         p, x, y;
		s4_d.pass = s3_q.pass;
		s4_d.kind = s3_q.kind;
		s4_d.bhit = s3_q.bhit;

		zero_a = (s3_q.a == '0);
		fail   = (!s3_q.bh[WW-1] && s3_q.bh != '0) || s3_q.c[WW-1];
		e1     = EW'(s3_q.a) + (EW'(s3_q.bh) <<< 1) + EW'(s3_q.c);
		le0    = e1[EW-1] || (e1 == '0);
		e2     = (WW+1)'(s3_q.a) + (WW+1)'(s3_q.bh);
		neg    = e2[WW];
		s4_d.decided = zero_a || fail || le0 || neg;
		s4_d.dhit    = !zero_a && !fail && le0;

		// bh^2 against a*c on nonnegative magnitudes
		nbh = -s3_q.bh;
		p   = nbh[MW-1:0];
		x   = s3_q.a[MW-1:0];
		y   = s3_q.c[MW-1:0];
		s4_d.p_hh = PPW'(p[MW-1:HW]) * PPW'(p[MW-1:HW]);
		s4_d.p_hl = PPW'(p[MW-1:HW]) * PPW'(p[HW-1:0]);
		s4_d.p_ll = PPW'(p[HW-1:0])  * PPW'(p[HW-1:0]);
		s4_d.q_hh = PPW'(x[MW-1:HW]) * PPW'(y[MW-1:HW]);
		s4_d.q_hl = PPW'(x[MW-1:HW]) * PPW'(y[HW-1:0]);
		s4_d.q_lh = PPW'(x[HW-1:0])  * PPW'(y[MW-1:HW]);
		s4_d.q_ll = PPW'(x[HW-1:0])  * PPW'(y[HW-1:0]);
	end
endmodule

FILE: rtl/cpt_merge.sv
// ----------------------------------------------------------------------------
// cpt_merge
// Fifth stage: recombine partial products into the full square and product.
// ----------------------------------------------------------------------------
module cpt_merge
	import cpt_pkg::*;
(
	input  s4_t s4_q,
	output s5_t s5_d
);
	always_comb begin
		s5_d.pass    = s4_q.pass;
		s5_d.kind    = s4_q.kind;
		s5_d.bhit    = s4_q.bhit;
		s5_d.decided = s4_q.decided;
		s5_d.dhit    = s4_q.dhit;
		s5_d.lhs = (FW'(s4_q.p_hh) << (2*HW)) + (FW'(s4_q.p_hl) << (HW+1)) +
			FW'(s4_q.p_ll);
		s5_d.rhs = (FW'(s4_q.q_hh) << (2*HW)) +
			((FW'(s4_q.q_hl) + FW'(s4_q.q_lh)) << HW) + FW'(s4_q.q_ll);
	end
endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the collision pair test: random and directed pair beats with
// bursty request traffic and a stalling result side, checked against an
// in-bench model of the filter, the swept sphere test and the box/sphere test.
// ----------------------------------------------------------------------------
module tb_top;
	import cpt_pkg::*;

	localparam int LATENCY   = 6;
	localparam int N_RANDOM  = 600;
	localparam int MAX_CYCLE = 200000;

	typedef struct {
		logic hit;
		logic filter_pass;
	} verdict_t;

	logic clk;
	logic arst_n;

	cpt_req_if req ();
	cpt_rsp_if rsp ();

	collision_pair_test i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	req_t     pending_pairs[$];
	verdict_t expected_verdicts[$];
	int       errors;
	int       cycle;
	bit       stim_done;
	bit       hold_for_drain;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Components of a packed Q8.8 triple, sign or zero extended to 64 bits.
	function automatic longint sc(input logic [47:0] v, input int i);
		logic signed [15:0] x;
		x = v[i*16 +: 16];
		return longint'(x);
	endfunction

	function automatic longint uc(input logic [47:0] v, input int i);
		return longint'({48'd0, v[i*16 +: 16]});
	endfunction

	// Swept sphere test: first root of |st + t*d|^2 = r^2 within [0,1].
	function automatic bit spheres_touch(input req_t p);
		longint qa, qb, qc, d, st, r;
		logic [127:0] lhs, rhs;
		qa = 0; qb = 0; qc = 0;
		for (int i = 0; i < 3; i++) begin
			d = (sc(p.a_curr_pos, i) - sc(p.a_prev_pos, i)) -
				(sc(p.b_curr_pos, i) - sc(p.b_prev_pos, i));
			st = sc(p.a_prev_pos, i) - sc(p.b_prev_pos, i);
			qa += d * d;
			qb += st * d;
			qc += st * st;
		end
		r = uc(p.a_extent, 0) + uc(p.b_extent, 0);
		qc = qc - r * r;
		if (qa == 0 || qb > 0 || qc < 0)
			return 1'b0;
		if (qa + 2 * qb + qc <= 0)
			return 1'b1;
		if (qa + qb < 0)
			return 1'b0;
		lhs = 128'(-qb) * 128'(-qb);
		rhs = 128'(qa) * 128'(qc);
		return lhs >= rhs;
	endfunction

	// Closest point of the box to the sphere center, compared with the radius.
	function automatic bit box_reaches(input logic [47:0] bpos, input logic [47:0] bext,
			input logic [47:0] spos, input logic [47:0] sext);
		longint sum, lo, hi, c, q, r;
		sum = 0;
		r = uc(sext, 0);
		for (int i = 0; i < 3; i++) begin
			lo = sc(bpos, i) - uc(bext, i);
			hi = sc(bpos, i) + uc(bext, i);
			c = sc(spos, i);
			q = c < lo ? lo : (c > hi ? hi : c);
			sum += (q - c) * (q - c);
		end
		return sum <= r * r;
	endfunction

	function automatic verdict_t judge_pair(input req_t p);
		verdict_t v;
		v.filter_pass = ((p.a_attribute & p.b_mask) != 0) && ((p.a_mask & p.b_attribute) != 0);
		v.hit = 1'b0;
		if (v.filter_pass) begin
			case (kind_t'(p.kind))
				KIND_SPH_SPH: v.hit = spheres_touch(p);
				KIND_BOX_SPH: v.hit = box_reaches(p.a_curr_pos, p.a_extent, p.b_curr_pos, p.b_extent);
				KIND_SPH_BOX: v.hit = box_reaches(p.b_curr_pos, p.b_extent, p.a_curr_pos, p.a_extent);
				default: v.hit = 1'b0;
			endcase
		end
		return v;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	// Small signed coordinate near the origin, in whole and fractional units.
	function automatic logic [15:0] near_coord(input int span);
		int v;
		v = int'($urandom_range(2 * span, 0)) - span;
		return 16'(v);
	endfunction

	function automatic logic [47:0] near_pos(input int span);
		return {near_coord(span), near_coord(span), near_coord(span)};
	endfunction

	function automatic logic [47:0] near_ext(input int span);
		return {16'($urandom_range(span, 0)), 16'($urandom_range(span, 0)),
			16'($urandom_range(span, 0))};
	endfunction

	function automatic req_t random_pair();
		req_t p;
		int   mode;
		int   span;
		mode = $urandom_range(9, 0);
		p.kind = 2'($urandom_range(3, 0));
		// Mostly filters that pass, with random extra bits.
		if (mode == 0) begin
			p.a_attribute = $urandom(); p.a_mask = $urandom();
			p.b_attribute = $urandom(); p.b_mask = $urandom();
		end else begin
			p.a_attribute = $urandom() | 32'h1; p.b_mask = $urandom() | 32'h1;
			p.a_mask = $urandom() | 32'h80000000; p.b_attribute = $urandom() | 32'h80000000;
		end
		if (mode == 1) begin
			// Full range noise, extremes of every bit.
			p.a_prev_pos = rand48(); p.a_curr_pos = rand48();
			p.b_prev_pos = rand48(); p.b_curr_pos = rand48();
			p.a_extent = rand48(); p.b_extent = rand48();
		end else begin
			// Shapes close together, so hits and misses are both common.
			span = (mode < 5) ? 1024 : 8192;
			p.a_prev_pos = near_pos(span);
			p.b_prev_pos = near_pos(span);
			p.a_curr_pos = ($urandom_range(5, 0) == 0) ? p.a_prev_pos : near_pos(span);
			p.b_curr_pos = ($urandom_range(5, 0) == 0) ? p.b_prev_pos : near_pos(span);
			p.a_extent = near_ext(span / 2);
			p.b_extent = near_ext(span / 2);
		end
		return p;
	endfunction

	function automatic req_t make_pair(input kind_t k, input logic [47:0] ap, input logic [47:0] ac,
			input logic [47:0] bp, input logic [47:0] bc, input logic [47:0] ae,
			input logic [47:0] be);
		req_t p;
		p.kind = k;
		p.a_attribute = 32'h1; p.a_mask = 32'h2; p.b_attribute = 32'h2; p.b_mask = 32'h1;
		p.a_prev_pos = ap; p.a_curr_pos = ac; p.b_prev_pos = bp; p.b_curr_pos = bc;
		p.a_extent = ae; p.b_extent = be;
		return p;
	endfunction

	// Directed pairs, then the random stream.
	initial begin
		req_t p;
		// sphere pair sweeping through each other
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h0, 48'h0000_0000_0a00,
			48'h0000_0000_0500, 48'h0000_0000_0500, 48'h0100, 48'h0100));
		// no relative motion while overlapping: no hit
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h0, 48'h0100,
			48'h0080, 48'h0180, 48'h0100, 48'h0100));
		// moving sideways, never in reach: negative discriminant, no hit
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h0, 48'h0000_0100_0000,
			48'h0000_0000_0800, 48'h0000_0000_0800, 48'h0100, 48'h0100));
		// touching exactly at the end of the frame
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h0, 48'h0200,
			48'h0400, 48'h0400, 48'h0100, 48'h0100));
		// touching exactly at the start of the frame
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h0400, 48'h0000,
			48'h0200, 48'h0200, 48'h0100, 48'h0100));
		// box/sphere touching at distance equal to radius, and just short
		pending_pairs.push_back(make_pair(KIND_BOX_SPH, 48'h0, 48'h0,
			48'h0, 48'h0300, 48'h0100_0100_0100, 48'h0200));
		pending_pairs.push_back(make_pair(KIND_BOX_SPH, 48'h0, 48'h0,
			48'h0, 48'h0301, 48'h0100_0100_0100, 48'h0200));
		pending_pairs.push_back(make_pair(KIND_SPH_BOX, 48'h0, 48'h0300,
			48'h0, 48'h0, 48'h0200, 48'h0100_0100_0100));
		pending_pairs.push_back(make_pair(KIND_SPH_BOX, 48'h0, 48'hff00_ff00_ff00,
			48'h0, 48'h0, 48'h0001, 48'h0100_0100_0100));
		// box with box, overlapping: never a hit
		pending_pairs.push_back(make_pair(KIND_BOX_BOX, 48'h0, 48'h0,
			48'h0, 48'h0, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff));
		// extreme coordinates and extents
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h7fff_7fff_7fff, 48'h8000_8000_8000,
			48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff));
		pending_pairs.push_back(make_pair(KIND_SPH_SPH, 48'h8000_8000_8000, 48'h7fff_7fff_7fff,
			48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h0, 48'h0));
		pending_pairs.push_back(make_pair(KIND_BOX_SPH, 48'h7fff_7fff_7fff, 48'h8000_8000_8000,
			48'h0, 48'h7fff_7fff_7fff, 48'hffff_ffff_ffff, 48'hffff));
		pending_pairs.push_back(make_pair(KIND_SPH_BOX, 48'h0, 48'h8000_8000_8000,
			48'h0, 48'h7fff_7fff_7fff, 48'h0, 48'hffff_ffff_ffff));
		// filter fails on either side, and all ones
		p = make_pair(KIND_SPH_SPH, 48'h0, 48'h0a00, 48'h0500, 48'h0500, 48'h0100, 48'h0100);
		p.b_mask = 32'h0;
		pending_pairs.push_back(p);
		p.b_mask = 32'h1; p.b_attribute = 32'h4;
		pending_pairs.push_back(p);
		p.a_attribute = '1; p.a_mask = '1; p.b_attribute = '1; p.b_mask = '1;
		pending_pairs.push_back(p);
		p.a_attribute = 32'h80000000; p.b_mask = 32'h80000000;
		p.a_mask = 32'h0; p.b_attribute = '1;
		pending_pairs.push_back(p);
		for (int i = 0; i < N_RANDOM; i++)
			pending_pairs.push_back(random_pair());
	end

	// Reset, then watch for the end of the stimulus and the drain.
	initial begin
		arst_n = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done && expected_verdicts.size() == 0);
		repeat (LATENCY * 4) @(posedge clk);
		if (errors == 0 && expected_verdicts.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Bound the run.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("TEST FAILED");
			$finish;
		end
	end
	initial cycle = 0;

	// Request driver: bursts and gaps, change at the falling edge.
	int  burst_left;
	int  gap_left;
	int  sent;
	bit  drained_once;
	initial begin
		req.valid = 1'b0;
		req.kind = '0;
		req.a_attribute = '0; req.a_mask = '0; req.b_attribute = '0; req.b_mask = '0;
		req.a_prev_pos = '0; req.a_curr_pos = '0; req.b_prev_pos = '0; req.b_curr_pos = '0;
		req.a_extent = '0; req.b_extent = '0;
		burst_left = 0; gap_left = 0; sent = 0; drained_once = 1'b0;
		hold_for_drain = 1'b0;
	end

	always @(negedge clk) begin
		req_t head;
		bit   popped;
		if (arst_n) begin
			// Drop the beat that was taken at the last rising edge.
			popped = req.valid && req.ready;
			if (popped) begin
				void'(pending_pairs.pop_front());
				sent = sent + 1;
				if (burst_left > 0)
					burst_left = burst_left - 1;
			end
			// Hold off once mid-run until every result is back.
			if (!drained_once && !hold_for_drain && sent == 300)
				hold_for_drain = 1'b1;
			else if (hold_for_drain && expected_verdicts.size() == 0) begin
				hold_for_drain = 1'b0;
				drained_once = 1'b1;
			end
			// A waiting beat holds; otherwise pick the next one or idle.
			if (!req.valid || popped) begin
				if (pending_pairs.size() == 0) begin
					req.valid <= 1'b0;
					stim_done = 1'b1;
				end else if (hold_for_drain) begin
					req.valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left = gap_left - 1;
					req.valid <= 1'b0;
				end else if (popped && burst_left == 0) begin
					// End of a burst: pick a gap, sometimes none.
					gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
					burst_left = $urandom_range(40, 1);
					req.valid <= 1'b0;
				end else begin
					if (burst_left == 0)
						burst_left = $urandom_range(40, 1);
					head = pending_pairs[0];
					req.valid <= 1'b1;
					req.kind <= head.kind;
					req.a_attribute <= head.a_attribute; req.a_mask <= head.a_mask;
					req.b_attribute <= head.b_attribute; req.b_mask <= head.b_mask;
					req.a_prev_pos <= head.a_prev_pos; req.a_curr_pos <= head.a_curr_pos;
					req.b_prev_pos <= head.b_prev_pos; req.b_curr_pos <= head.b_curr_pos;
					req.a_extent <= head.a_extent; req.b_extent <= head.b_extent;
				end
			end
		end
	end

	// Result side stall pattern: long ready runs, mixed with random stalls.
	int stall_phase;
	initial begin
		rsp.ready = 1'b0;
		stall_phase = 0;
	end
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		case ((stall_phase / 64) % 4)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(3, 0) != 0);
			2: rsp.ready <= ($urandom_range(3, 0) == 0);
			default: rsp.ready <= stall_phase[2];
		endcase
	end

	// Monitor: predict on every accepted request beat, check every result beat.
	always @(posedge clk) begin
		req_t     taken;
		verdict_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				taken.kind = req.kind;
				taken.a_attribute = req.a_attribute; taken.a_mask = req.a_mask;
				taken.b_attribute = req.b_attribute; taken.b_mask = req.b_mask;
				taken.a_prev_pos = req.a_prev_pos; taken.a_curr_pos = req.a_curr_pos;
				taken.b_prev_pos = req.b_prev_pos; taken.b_curr_pos = req.b_curr_pos;
				taken.a_extent = req.a_extent; taken.b_extent = req.b_extent;
				expected_verdicts.push_back(judge_pair(taken));
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("result beat with no pair outstanding");
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (rsp.hit !== want.hit) begin
						$error("hit: expected %0b, got %0b", want.hit, rsp.hit);
						errors++;
					end
					if (rsp.filter_pass !== want.filter_pass) begin
						$error("filter_pass: expected %0b, got %0b",
							want.filter_pass, rsp.filter_pass);
						errors++;
					end
				end
			end
		end
	end

endmodule

FILE: files.f
rtl/cpt_pkg.sv
rtl/cpt_if.sv
rtl/cpt_prep.sv
rtl/cpt_mult.sv
rtl/cpt_accum.sv
rtl/cpt_split.sv
rtl/cpt_merge.sv
rtl/collision_pair_test.sv
dv/tb_top.sv
